// ===== hw/rtl/bevs_pkg.sv =====
package bevs_pkg;

    typedef enum logic [2:0] {
        CMD_PUT8    = 3'd0,
        CMD_PUT16   = 3'd1,
        CMD_PUT32   = 3'd2,
        CMD_PUT64   = 3'd3,
        CMD_PUT_ENC = 3'd4,
        CMD_SEEK    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_EMIT  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_SEEK  = 2'd2
    } t_kind;

    localparam logic [20:0] ENC_2B_MIN  = 21'h00080;
    localparam logic [20:0] ENC_3B_MIN  = 21'h00800;
    localparam logic [20:0] ENC_4B_MIN  = 21'h10000;
    localparam logic [20:0] ENC_LIMIT   = 21'h110000;
    localparam logic [7:0]  LEAD_2B     = 8'hC0;
    localparam logic [7:0]  LEAD_3B     = 8'hE0;
    localparam logic [7:0]  LEAD_4B     = 8'hF0;
    localparam logic [7:0]  CONT_BYTE   = 8'h80;
    localparam logic [7:0]  ASCII_MASK  = 8'h7F;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] byte_offset;
        logic        last_byte;
        logic        encode_error;
    } t_out_item;

    // bytes[0] goes out first; for seek, bytes[3:0] holds the new position
    typedef struct packed {
        t_kind           kind;
        logic [2:0]      last_idx;
        logic [7:0][7:0] bytes;
    } t_entry;

endpackage

// ===== hw/rtl/bevs_front.sv =====
module bevs_front import bevs_pkg::*; (
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_ready,
    output logic     o_push,
    output t_entry   o_entry
);

    logic [63:0] v;
    logic        known;

    assign v       = i_item.value;
    assign o_ready = !i_full;

    always_comb begin
        o_entry          = '0;
        o_entry.kind     = KIND_EMIT;
        o_entry.last_idx = 3'd0;
        known            = 1'b1;
        unique case (i_item.command)
            CMD_PUT8: begin
                o_entry.bytes[0] = v[7:0];
            end
            CMD_PUT16: begin
                o_entry.last_idx = 3'd1;
                o_entry.bytes[0] = v[15:8];
                o_entry.bytes[1] = v[7:0];
            end
            CMD_PUT32: begin
                o_entry.last_idx = 3'd3;
                o_entry.bytes[0] = v[31:24];
                o_entry.bytes[1] = v[23:16];
                o_entry.bytes[2] = v[15:8];
                o_entry.bytes[3] = v[7:0];
            end
            CMD_PUT64: begin
                o_entry.last_idx = 3'd7;
                o_entry.bytes[0] = v[63:56];
                o_entry.bytes[1] = v[55:48];
                o_entry.bytes[2] = v[47:40];
                o_entry.bytes[3] = v[39:32];
                o_entry.bytes[4] = v[31:24];
                o_entry.bytes[5] = v[23:16];
                o_entry.bytes[6] = v[15:8];
                o_entry.bytes[7] = v[7:0];
            end
            CMD_PUT_ENC: begin
                if (v[63:21] != '0 || v[20:0] >= ENC_LIMIT) begin
                    o_entry.kind = KIND_ERROR;
                end else if (v[20:0] < ENC_2B_MIN) begin
                    o_entry.bytes[0] = v[7:0] & ASCII_MASK;
                end else if (v[20:0] < ENC_3B_MIN) begin
                    o_entry.last_idx = 3'd1;
                    o_entry.bytes[0] = LEAD_2B | {3'b000, v[10:6]};
                    o_entry.bytes[1] = CONT_BYTE | {2'b00, v[5:0]};
                end else if (v[20:0] < ENC_4B_MIN) begin
                    o_entry.last_idx = 3'd2;
                    o_entry.bytes[0] = LEAD_3B | {4'b0000, v[15:12]};
                    o_entry.bytes[1] = CONT_BYTE | {2'b00, v[11:6]};
                    o_entry.bytes[2] = CONT_BYTE | {2'b00, v[5:0]};
                end else begin
                    o_entry.last_idx = 3'd3;
                    o_entry.bytes[0] = LEAD_4B | {5'b00000, v[20:18]};
                    o_entry.bytes[1] = CONT_BYTE | {2'b00, v[17:12]};
                    o_entry.bytes[2] = CONT_BYTE | {2'b00, v[11:6]};
                    o_entry.bytes[3] = CONT_BYTE | {2'b00, v[5:0]};
                end
            end
            CMD_SEEK: begin
                o_entry.kind         = KIND_SEEK;
                o_entry.bytes[3:0]   = v[31:0];
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // undefined commands are accepted and dropped
    assign o_push = i_valid && !i_full && known;

endmodule

// ===== hw/rtl/bevs_fifo.sv =====
module bevs_fifo import bevs_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/bevs_back.sv =====
module bevs_back import bevs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_entry    i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic [31:0] r_pos, n_pos;
    logic [2:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    t_out_item   r_item, n_item;
    logic        can_load;

    assign can_load = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_pos   = r_pos;
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (i_head_valid) begin
            unique case (i_head.kind)
                KIND_SEEK: begin
                    n_pos = i_head.bytes[3:0];
                    o_pop = 1'b1;
                end
                KIND_ERROR: begin
                    if (can_load) begin
                        n_valid             = 1'b1;
                        n_item.out_byte     = '0;
                        n_item.byte_offset  = r_pos;
                        n_item.last_byte    = 1'b1;
                        n_item.encode_error = 1'b1;
                        o_pop               = 1'b1;
                    end
                end
                KIND_EMIT: begin
                    if (can_load) begin
                        n_valid             = 1'b1;
                        n_item.out_byte     = i_head.bytes[r_idx];
                        n_item.byte_offset  = r_pos;
                        n_item.last_byte    = (r_idx == i_head.last_idx);
                        n_item.encode_error = 1'b0;
                        n_pos               = r_pos + 32'd1;
                        if (r_idx == i_head.last_idx) begin
                            n_idx = '0;
                            o_pop = 1'b1;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

// ===== hw/rtl/big_endian_varint_serializer_unit.sv =====
// Serializer of fixed-width big-endian and UTF-8 style variable-length values.
// Input channel (i_valid/o_ready, i_item): one command and a 64-bit value per
// item. Output channel (o_valid/i_ready, o_item): one stream byte per item,
// tagged with its 32-bit stream offset; last_byte marks the final byte of a
// command, encode_error marks the single result of an oversized encoded put.
// An accepted command passes through the queue and then the output register.
// The output runs at one byte per cycle while the receiver takes them; a
// command gives 1 to 8 bytes, or one item for an error; seek gives no output;
// commands 6 and 7 are accepted and dropped. The front accepts an item every
// cycle while the QUEUE_DEPTH-entry queue has room, so sustained rate is set
// by the byte count of the commands.
// Reset clears the queue, the output valid flag and the stream position (0).
// When the receiver stalls, the current byte holds in the output register,
// the back end stops but for seeks, and the front keeps taking items until the queue fills.
module big_endian_varint_serializer_unit import bevs_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic   push, pop, full, head_valid;
    t_entry push_entry, head_entry;

    bevs_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_ready (o_ready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    bevs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_entry (head_entry)
    );

    bevs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item       (o_item)
    );

endmodule

// ===== test/bevs_stream_checker.sv =====
module bevs_stream_checker import bevs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    t_out_item   expected_bytes[$];
    logic [31:0] write_pos = '0;
    int          fail_count = 0;

    function automatic void push_byte(logic [7:0] b, logic last);
        t_out_item e;
        e.out_byte     = b;
        e.byte_offset  = write_pos;
        e.last_byte    = last;
        e.encode_error = 1'b0;
        expected_bytes.push_back(e);
        write_pos = write_pos + 32'd1;
    endfunction

    function automatic void predict_serialize(t_in_item it);
        logic [63:0] v;
        t_out_item   e;
        int          n;
        int          k;
        v = it.value;
        case (it.command)
            CMD_PUT8, CMD_PUT16, CMD_PUT32, CMD_PUT64: begin
                n = 1 << it.command;
                for (k = 0; k < n; k++)
                    push_byte(8'(v >> (8 * (n - 1 - k))), k == n - 1);
            end
            CMD_PUT_ENC: begin
                if (v < ENC_2B_MIN) begin
                    push_byte(v[7:0] & ASCII_MASK, 1'b1);
                end else if (v < ENC_3B_MIN) begin
                    push_byte(LEAD_2B | {3'b0, v[10:6]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[5:0]}, 1'b1);
                end else if (v < ENC_4B_MIN) begin
                    push_byte(LEAD_3B | {4'b0, v[15:12]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[11:6]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[5:0]}, 1'b1);
                end else if (v < ENC_LIMIT) begin
                    push_byte(LEAD_4B | {5'b0, v[20:18]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[17:12]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[11:6]}, 1'b0);
                    push_byte(CONT_BYTE | {2'b0, v[5:0]}, 1'b1);
                end else begin
                    // too large: single error item, position unchanged
                    e.out_byte     = '0;
                    e.byte_offset  = write_pos;
                    e.last_byte    = 1'b1;
                    e.encode_error = 1'b1;
                    expected_bytes.push_back(e);
                end
            end
            CMD_SEEK: write_pos = v[31:0];
            default: ;
        endcase
    endfunction

    function automatic void check_byte(t_out_item got);
        t_out_item e;
        if (expected_bytes.size() == 0) begin
            $error("unexpected item: out_byte %h byte_offset %h", got.out_byte,
                   got.byte_offset);
            fail_count++;
            return;
        end
        e = expected_bytes.pop_front();
        if (got.out_byte !== e.out_byte) begin
            $error("out_byte: expected %h, actual %h", e.out_byte, got.out_byte);
            fail_count++;
        end
        if (got.byte_offset !== e.byte_offset) begin
            $error("byte_offset: expected %h, actual %h", e.byte_offset,
                   got.byte_offset);
            fail_count++;
        end
        if (got.last_byte !== e.last_byte) begin
            $error("last_byte: expected %b, actual %b", e.last_byte, got.last_byte);
            fail_count++;
        end
        if (got.encode_error !== e.encode_error) begin
            $error("encode_error: expected %b, actual %b", e.encode_error,
                   got.encode_error);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            write_pos = '0;
        end else begin
            if (i_in_valid && i_in_ready)
                predict_serialize(i_in_item);
            if (i_out_valid && i_out_ready)
                check_byte(i_out_item);
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/tb_big_endian_varint_serializer_unit.sv =====
module tb_big_endian_varint_serializer_unit;
    import bevs_pkg::*;

    localparam logic [2:0] CMD_UNDEF_A    = 3'd6;
    localparam logic [2:0] CMD_UNDEF_B    = 3'd7;
    localparam int         HOLD_CYCLES    = 90;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    int fail_count;
    int pending;
    int send_idle = 28;
    int recv_idle = 46;
    bit hold_req = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    big_endian_varint_serializer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    bevs_stream_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_item(input logic [2:0] cmd, input logic [63:0] val);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_item.command <= cmd;
        i_item.value   <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(output bit counted);
        logic [63:0] v;
        logic [2:0]  cmd;
        int          sel;
        sel = $urandom_range(99);
        v   = {$urandom, $urandom};
        if (sel < 10) begin
            cmd = CMD_PUT8;
        end else if (sel < 20) begin
            cmd = CMD_PUT16;
        end else if (sel < 30) begin
            cmd = CMD_PUT32;
        end else if (sel < 42) begin
            cmd = CMD_PUT64;
        end else if (sel < 78) begin
            cmd = CMD_PUT_ENC;
            case ($urandom_range(5))
                0: v = 64'($urandom_range(0, 'h7F));
                1: v = 64'($urandom_range('h80, 'h7FF));
                2: v = 64'($urandom_range('h800, 'hFFFF));
                3: v = 64'($urandom_range('h10000, 'h10FFFF));
                4: v = 64'($urandom_range('h110000, 'h1FFFFF));
                default: ;
            endcase
        end else if (sel < 90) begin
            cmd = CMD_SEEK;
            if ($urandom_range(3) == 0)
                v[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(10));
        end else begin
            cmd = $urandom_range(1) ? CMD_UNDEF_A : CMD_UNDEF_B;
        end
        counted = (cmd != CMD_UNDEF_A) && (cmd != CMD_UNDEF_B);
        send_item(cmd, v);
    endtask

    task automatic run_random(input int count);
        int done;
        bit counted;
        done = 0;
        while (done < count) begin
            send_random(counted);
            done += counted;
        end
    endtask

    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fixed-width puts, upper bits must be dropped
        send_item(CMD_PUT8,  64'h0);
        send_item(CMD_PUT8,  64'hFFFF_FFFF_FFFF_FF5A);
        send_item(CMD_PUT16, 64'hA5A5_A5A5_A5A5_1234);
        send_item(CMD_PUT32, 64'hFFFF_FFFF_8000_0001);
        send_item(CMD_PUT64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PUT64, 64'h0123_4567_89AB_CDEF);
        // encoded length boundaries, surrogate, too large
        send_item(CMD_PUT_ENC, 64'h0);
        send_item(CMD_PUT_ENC, 64'h7F);
        send_item(CMD_PUT_ENC, 64'h80);
        send_item(CMD_PUT_ENC, 64'h7FF);
        send_item(CMD_PUT_ENC, 64'h800);
        send_item(CMD_PUT_ENC, 64'hFFFF);
        send_item(CMD_PUT_ENC, 64'hD800);
        send_item(CMD_PUT_ENC, 64'h10000);
        send_item(CMD_PUT_ENC, 64'h10FFFF);
        send_item(CMD_PUT_ENC, 64'h110000);
        send_item(CMD_PUT_ENC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PUT_ENC, 64'h0000_0001_0000_0041);
        // seek near the top, then wrap the position
        send_item(CMD_SEEK,    64'hDEAD_BEEF_FFFF_FFFD);
        send_item(CMD_PUT32,   64'h1122_3344);
        send_item(CMD_PUT_ENC, 64'h8000_0000_0000_0000);
        send_item(CMD_UNDEF_A, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_UNDEF_B, 64'h0);
        send_item(CMD_SEEK,    64'h0);
        send_item(CMD_PUT8,    64'hC3);

        // long receiver stall with back-to-back puts to fill the queue
        send_idle = 0;
        hold_req  = 1'b1;
        repeat (16) send_item(CMD_PUT64, {$urandom, $urandom});

        send_idle = 28;
        recv_idle = 46;
        run_random(111);
        send_idle = 46;
        recv_idle = 28;
        run_random(111);
        send_idle = 0;
        recv_idle = 0;
        run_random(110);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
